// File: rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked implication with reset disable.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked implication that also holds during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/rqi_pkg.sv
package rqi_pkg;
  localparam int CoordWidth = 21;
  localparam int DistWidth = 32;
  localparam int PosFrac = 13;
  localparam int DirFrac = 19;
  localparam int DistFrac = 20;
  localparam int EpsNum = 1678;
  localparam int EpsShift = 24;
  localparam int RegWidth = 63;
  localparam int IdxWidth = 3;

  typedef enum logic [IdxWidth-1:0] {
    REG_CORNER_A = 3'd0,
    REG_CORNER_B = 3'd1,
    REG_CORNER_C = 3'd2,
    REG_CORNER_D = 3'd3,
    REG_UNIT_NORMAL = 3'd4
  } reg_idx_t;
endpackage

// File: rtl/rqi_tri.sv
// One triangle of the quad: edge and cross-product stages, dot products,
// epsilon tests, then a pipelined restoring divider producing t.
module rqi_tri #(
  parameter int CW = rqi_pkg::CoordWidth,
  parameter int DW = rqi_pkg::DistWidth
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CW-1:0] o [3],
  input  logic signed [CW-1:0] d [3],
  input  logic signed [CW-1:0] a [3],
  input  logic signed [CW-1:0] b [3],
  input  logic signed [CW-1:0] c [3],
  output logic                 ok,
  output logic [DW-1:0]        tval
);
  import rqi_pkg::*;

  localparam int EW = CW + 1;
  localparam int PW = 2 * EW + 1;
  localparam int DTW = PW + EW + 2;
  localparam int SH = DirFrac - PosFrac + DistFrac;
  localparam int NW = DTW + SH + 1;
  localparam int CWW = DTW + EpsShift + 13;
  localparam int LW = DTW + SH + DW;

  // stage 1: edges
  logic signed [EW-1:0] e1 [3], e2 [3], tv [3];
  logic signed [CW-1:0] d1 [3];
  // stage 2: cross products
  logic signed [PW-1:0] p [3], q [3];
  logic signed [EW-1:0] e1b [3], e2b [3], tvb [3];
  logic signed [CW-1:0] d2 [3];
  // stage 3: dots
  logic signed [DTW-1:0] det, un, vn, tn;
  // stage 4: tests
  logic          ok4, sat4;
  logic [NW-1:0] num4;
  logic [DTW-1:0] den4;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        e1[k] <= EW'(b[k]) - EW'(a[k]);
        e2[k] <= EW'(c[k]) - EW'(a[k]);
        tv[k] <= EW'(o[k]) - EW'(a[k]);
        d1[k] <= d[k];
      end
      p[0] <= PW'(d1[1] * e2[2]) - PW'(d1[2] * e2[1]);
      p[1] <= PW'(d1[2] * e2[0]) - PW'(d1[0] * e2[2]);
      p[2] <= PW'(d1[0] * e2[1]) - PW'(d1[1] * e2[0]);
      q[0] <= PW'(tv[1] * e1[2]) - PW'(tv[2] * e1[1]);
      q[1] <= PW'(tv[2] * e1[0]) - PW'(tv[0] * e1[2]);
      q[2] <= PW'(tv[0] * e1[1]) - PW'(tv[1] * e1[0]);
      e1b <= e1; e2b <= e2; tvb <= tv; d2 <= d1;
      det <= DTW'(p[0] * e1b[0]) + DTW'(p[1] * e1b[1]) + DTW'(p[2] * e1b[2]);
      un <= DTW'(p[0] * tvb[0]) + DTW'(p[1] * tvb[1]) + DTW'(p[2] * tvb[2]);
      vn <= DTW'(q[0] * d2[0]) + DTW'(q[1] * d2[1]) + DTW'(q[2] * d2[2]);
      tn <= DTW'(q[0] * e2b[0]) + DTW'(q[1] * e2b[1]) + DTW'(q[2] * e2b[2]);
    end
  end

  logic signed [CWW-1:0] epsdet, ut, vt, uvt, dt, tt;
  logic signed [LW-1:0] numw, lim;
  always_comb begin
    epsdet = CWW'(det) * CWW'(EpsNum);
    ut = CWW'(un) <<< EpsShift;
    vt = CWW'(vn) <<< EpsShift;
    uvt = (CWW'(un) + CWW'(vn)) <<< EpsShift;
    dt = CWW'(det) <<< EpsShift;
    tt = CWW'(tn) <<< (EpsShift + DirFrac - PosFrac);
    numw = LW'(tn) <<< SH;
    lim = LW'(det) <<< DW;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ok4 <= (det > 0) && (ut + epsdet >= 0) && (vt + epsdet >= 0)
             && !(uvt > dt + epsdet) && !(tt < epsdet);
      sat4 <= numw >= lim;
      num4 <= numw[NW-1:0];
      den4 <= det;
    end
  end

  // Restoring divider, one quotient bit per stage.
  logic          vok [DW+1];
  logic          vsat [DW+1];
  logic [NW-1:0] rem [DW+1];
  logic [DTW-1:0] den [DW+1];
  logic [DW-1:0] quo [DW+1];
  always_comb begin
    vok[0] = ok4; vsat[0] = sat4; rem[0] = num4; den[0] = den4; quo[0] = '0;
  end
  for (genvar i = 0; i < DW; i++) begin : g_div
    localparam int B = DW - 1 - i;
    logic [NW+DW-1:0] s;
    logic ge;
    assign s = (NW+DW)'(den[i]) << B;
    assign ge = (NW+DW)'(rem[i]) >= s;
    always_ff @(posedge clk) begin
      if (en) begin
        vok[i+1] <= vok[i];
        vsat[i+1] <= vsat[i];
        den[i+1] <= den[i];
        rem[i+1] <= ge ? NW'((NW+DW)'(rem[i]) - s) : rem[i];
        quo[i+1] <= quo[i] | (ge ? (DW'(1) << B) : '0);
      end
    end
  end

  assign ok = vok[DW];
  assign tval = vsat[DW] ? '1 : quo[DW];
endmodule

// File: rtl/ray_quad_intersect.sv
// Stages: edges, cross products, dots, tests, divider, output register.
// Throughput: one ray per cycle; a stalled output holds the whole pipeline,
// whose last stage is the output register.
// Reset: valid bits and configuration registers clear; data registers do not.
// The divider is unrolled, one quotient bit per pipeline stage.
module ray_quad_intersect #(
  parameter int COORD_WIDTH = rqi_pkg::CoordWidth,
  parameter int DIST_WIDTH = rqi_pkg::DistWidth
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rqi_pkg::IdxWidth-1:0] cfg_index,
  input  logic [rqi_pkg::RegWidth-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [20:0]          origin_x,
  input  logic signed [20:0]          origin_y,
  input  logic signed [20:0]          origin_z,
  input  logic signed [20:0]          dir_x,
  input  logic signed [20:0]          dir_y,
  input  logic signed [20:0]          dir_z,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        hit,
  output logic [DIST_WIDTH-1:0]       distance
);
  import rqi_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int LAT = DIST_WIDTH + 5;

  logic [RegWidth-1:0] regs [5];
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 5; k++) regs[k] <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CORNER_A: regs[0] <= cfg_data;
        REG_CORNER_B: regs[1] <= cfg_data;
        REG_CORNER_C: regs[2] <= cfg_data;
        REG_CORNER_D: regs[3] <= cfg_data;
        REG_UNIT_NORMAL: regs[4] <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [CW-1:0] va [3], vb [3], vc [3], vd [3], vn [3], o [3], d [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      va[k] = regs[0][k*CW +: CW];
      vb[k] = regs[1][k*CW +: CW];
      vc[k] = regs[2][k*CW +: CW];
      vd[k] = regs[3][k*CW +: CW];
      vn[k] = regs[4][k*CW +: CW];
    end
    o[0] = origin_x[CW-1:0]; o[1] = origin_y[CW-1:0]; o[2] = origin_z[CW-1:0];
    d[0] = dir_x[CW-1:0]; d[1] = dir_y[CW-1:0]; d[2] = dir_z[CW-1:0];
  end

  logic en;
  logic vld [LAT];
  assign en = !vld[LAT-1] || out_ready;
  assign in_ready = en;
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LAT; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int k = 1; k < LAT; k++) vld[k] <= vld[k-1];
    end
  end

  // Cull test, carried alongside the triangle pipes.
  localparam int DNW = 2 * CW + 2;
  logic signed [DNW-1:0] dn;
  logic cull [LAT-2];
  always_ff @(posedge clk) begin
    if (en) begin
      dn <= DNW'(d[0] * vn[0]) + DNW'(d[1] * vn[1]) + DNW'(d[2] * vn[2]);
      cull[0] <= dn <= -DNW'(EpsNum <<< (2 * DirFrac - EpsShift));
      for (int k = 1; k < LAT - 2; k++) cull[k] <= cull[k-1];
    end
  end

  logic h1, h2;
  logic [DIST_WIDTH-1:0] t1, t2;
  rqi_tri #(.CW(CW), .DW(DIST_WIDTH)) u_abc (
    .clk, .en, .o, .d, .a(va), .b(vb), .c(vc), .ok(h1), .tval(t1));
  rqi_tri #(.CW(CW), .DW(DIST_WIDTH)) u_acd (
    .clk, .en, .o, .d, .a(va), .b(vc), .c(vd), .ok(h2), .tval(t2));

  logic g1, g2;
  assign g1 = h1 && cull[LAT-3];
  assign g2 = h2 && cull[LAT-3];
  always_ff @(posedge clk) begin
    if (en) begin
      hit <= g1 || g2;
      if (g1 && g2) distance <= (t1 < t2) ? t1 : t2;
      else if (g1) distance <= t1;
      else if (g2) distance <= t2;
      else distance <= '0;
    end
  end
  assign out_valid = vld[LAT-1];
endmodule

// File: rtl/rqi_checker.sv
`include "assert_macros.svh"
module rqi_checker #(
  parameter int DW = rqi_pkg::DistWidth
) (
  input logic clk,
  input logic rst,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic hit,
  input logic [DW-1:0] distance
);
  `ASSERT_CLK(a_miss_zero, clk, rst, out_valid && !hit |-> distance == '0, "miss with distance")
  `ASSERT_CLK(a_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(distance), "out dropped")
  `ASSERT_CLK(a_ready, clk, rst, !out_valid |-> in_ready, "stall without output")
  `ASSERT_ALWAYS(a_rst, clk, rst |=> !out_valid, "valid after reset")
endmodule

bind ray_quad_intersect rqi_checker #(.DW(DIST_WIDTH)) u_rqi_checker (
  .clk, .rst, .in_ready, .out_valid, .out_ready, .hit, .distance);
